[hdl/tcpa_pkg.sv]
package tcpa_pkg;

  // Number formats.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int FIELD_W    = 16;
  localparam int PER_W      = 27;
  localparam int AREA_W     = 39;

  // Side length square root: radicand is (dx^2 + dy^2) << 2*FRAC_BITS.
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int SIDE_W = (SQ_W + 2 * FRAC_BITS + 1) / 2;
  localparam int SRAD_W = 2 * SIDE_W;
  localparam int SREM_W = SIDE_W + 3;

  // Heron product and its square root.
  localparam int HALF_W  = PER_W;
  localparam int PROD_W  = 4 * PER_W;
  localparam int AROOT_W = 2 * PER_W;
  localparam int AREM_W  = AROOT_W + 3;
  localparam int AREA_SH = 2 + FRAC_BITS;

  // Clock edges from the one that accepts a word to the one that takes its result.
  localparam int LAT = 7 + SIDE_W + AROOT_W;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_start_x;
    logic signed [FIELD_W-1:0] a_start_y;
    logic signed [FIELD_W-1:0] a_end_x;
    logic signed [FIELD_W-1:0] a_end_y;
    logic signed [FIELD_W-1:0] b_start_x;
    logic signed [FIELD_W-1:0] b_start_y;
    logic signed [FIELD_W-1:0] b_end_x;
    logic signed [FIELD_W-1:0] b_end_y;
    logic signed [FIELD_W-1:0] c_start_x;
    logic signed [FIELD_W-1:0] c_start_y;
    logic signed [FIELD_W-1:0] c_end_x;
    logic signed [FIELD_W-1:0] c_end_y;
  } tcpa_in_t;

  typedef struct packed {
    logic              is_triangle;
    logic [PER_W-1:0]  perimeter_fx;
    logic [AREA_W-1:0] area_fx;
  } tcpa_out_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [SRAD_W-1:0] rad;
    logic [SREM_W-1:0] rem;
    logic [SIDE_W-1:0] root;
  } side_cell_t;

  typedef struct packed {
    logic [PROD_W-1:0]  rad;
    logic [AREM_W-1:0]  rem;
    logic [AROOT_W-1:0] root;
  } area_cell_t;

  // Reads the low COORD_BITS bits of a field as two's complement.
  function automatic logic signed [COORD_BITS-1:0] coord(input logic signed [FIELD_W-1:0] v);
    coord = COORD_BITS'(v);
  endfunction

  // Magnitude of the difference of two coordinates.
  function automatic logic [COORD_BITS-1:0] absdiff(input logic signed [COORD_BITS-1:0] p,
                                                    input logic signed [COORD_BITS-1:0] q);
    logic signed [COORD_BITS:0] d;
    d = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    absdiff = d[COORD_BITS-1:0];
  endfunction

endpackage

[hdl/tcpa_side_cell.sv]
module tcpa_side_cell (
  input  logic                 clk_i,
  input  tcpa_pkg::side_cell_t cell_i,
  output tcpa_pkg::side_cell_t cell_o
);
  import tcpa_pkg::*;

  logic [SREM_W-1:0] rem_sh;
  logic [SREM_W-1:0] trial;
  logic              fits;
  side_cell_t        cell_d;
  side_cell_t        cell_q;

  // One result bit: bring down two radicand bits and try to subtract.
  always_comb begin
    rem_sh      = {cell_i.rem[SREM_W-3:0], cell_i.rad[SRAD_W-1 -: 2]};
    trial       = SREM_W'({cell_i.root, 2'b01});
    fits        = (rem_sh >= trial);
    cell_d.rad  = {cell_i.rad[SRAD_W-3:0], 2'b00};
    cell_d.rem  = fits ? (rem_sh - trial) : rem_sh;
    cell_d.root = {cell_i.root[SIDE_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

[hdl/tcpa_area_cell.sv]
module tcpa_area_cell (
  input  logic                 clk_i,
  input  tcpa_pkg::area_cell_t cell_i,
  output tcpa_pkg::area_cell_t cell_o
);
  import tcpa_pkg::*;

  logic [AREM_W-1:0] rem_sh;
  logic [AREM_W-1:0] trial;
  logic              fits;
  area_cell_t        cell_d;
  area_cell_t        cell_q;

  // One result bit: bring down two radicand bits and try to subtract.
  always_comb begin
    rem_sh      = {cell_i.rem[AREM_W-3:0], cell_i.rad[PROD_W-1 -: 2]};
    trial       = AREM_W'({cell_i.root, 2'b01});
    fits        = (rem_sh >= trial);
    cell_d.rad  = {cell_i.rad[PROD_W-3:0], 2'b00};
    cell_d.rem  = fits ? (rem_sh - trial) : rem_sh;
    cell_d.root = {cell_i.root[AROOT_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

[hdl/triangle_check_perimeter_area_core.sv]
// Triangle check with perimeter and Heron area, fully pipelined.
// It accepts one word per cycle.
// The two square root cell chains have 25 cells per side and 54 for the area.
// busy_o stays low, and done_o marks each result for one cycle.
// Reset (rst_ni low, asynchronous) empties the pipeline; no result comes out of it.
module triangle_check_perimeter_area_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  tcpa_pkg::tcpa_in_t  in_i,
  output logic                done_o,
  output tcpa_pkg::tcpa_out_t res_o
);
  import tcpa_pkg::*;

  logic                  accept;
  logic [LAT-1:0]        vld_q;

  logic [COORD_BITS-1:0] dx_q [3];
  logic [COORD_BITS-1:0] dy_q [3];
  logic [SQ_W-1:0]       sum_q [3];
  logic                  cl_q [SIDE_W+2];
  logic                  closed;

  side_cell_t            sc [3][SIDE_W+1];
  area_cell_t            ac [AROOT_W+1];

  logic [SIDE_W-1:0]     la, lb, lc;
  logic                  ok;
  logic [PER_W-1:0]      per;
  logic [PER_W-1:0]      per_q;
  logic [PER_W-1:0]      da_q, db_q, dc_q;
  logic [2*PER_W-1:0]    m1_q, m2_q;
  logic [2*HALF_W-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic [PROD_W-1:0]     prod_q;

  logic                  ok_q [AROOT_W+4];
  logic [PER_W-1:0]      pp_q [AROOT_W+4];

  logic [AROOT_W-1:0]    area_full;
  tcpa_out_t             res_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Valid flag for every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // Loop closure test, first stage.
  always_comb begin
    closed = (coord(in_i.a_end_x) == coord(in_i.b_start_x)) &&
             (coord(in_i.a_end_y) == coord(in_i.b_start_y)) &&
             (coord(in_i.b_end_x) == coord(in_i.c_start_x)) &&
             (coord(in_i.b_end_y) == coord(in_i.c_start_y)) &&
             (coord(in_i.c_end_x) == coord(in_i.a_start_x)) &&
             (coord(in_i.c_end_y) == coord(in_i.a_start_y));
  end

  // Coordinate differences, then squared distances.
  always_ff @(posedge clk_i) begin
    dx_q[0] <= absdiff(coord(in_i.a_end_x), coord(in_i.a_start_x));
    dy_q[0] <= absdiff(coord(in_i.a_end_y), coord(in_i.a_start_y));
    dx_q[1] <= absdiff(coord(in_i.b_end_x), coord(in_i.b_start_x));
    dy_q[1] <= absdiff(coord(in_i.b_end_y), coord(in_i.b_start_y));
    dx_q[2] <= absdiff(coord(in_i.c_end_x), coord(in_i.c_start_x));
    dy_q[2] <= absdiff(coord(in_i.c_end_y), coord(in_i.c_start_y));
    for (int j = 0; j < 3; j++) begin
      sum_q[j] <= (SQ_W'(dx_q[j]) * SQ_W'(dx_q[j])) + (SQ_W'(dy_q[j]) * SQ_W'(dy_q[j]));
    end
    cl_q[0] <= closed;
    for (int k = 1; k < SIDE_W + 2; k++) begin
      cl_q[k] <= cl_q[k-1];
    end
  end

  // Three side chains of square root cells.
  for (genvar j = 0; j < 3; j++) begin : g_side
    assign sc[j][0].rad  = SRAD_W'(sum_q[j]) << (2 * FRAC_BITS);
    assign sc[j][0].rem  = '0;
    assign sc[j][0].root = '0;
    for (genvar k = 0; k < SIDE_W; k++) begin : g_cell
      tcpa_side_cell u_cell (
        .clk_i  (clk_i),
        .cell_i (sc[j][k]),
        .cell_o (sc[j][k+1])
      );
    end
  end

  // Triangle inequalities and perimeter.
  always_comb begin
    la  = sc[0][SIDE_W].root;
    lb  = sc[1][SIDE_W].root;
    lc  = sc[2][SIDE_W].root;
    ok  = cl_q[SIDE_W+1] &&
          ({1'b0, la} < ({1'b0, lb} + {1'b0, lc})) &&
          ({1'b0, lb} < ({1'b0, lc} + {1'b0, la})) &&
          ({1'b0, lc} < ({1'b0, la} + {1'b0, lb}));
    per = PER_W'(la) + PER_W'(lb) + PER_W'(lc);
  end

  // Heron product: perimeter and differences, two half products, four partial products, then the sum.
  always_ff @(posedge clk_i) begin
    per_q  <= per;
    da_q   <= per - PER_W'({la, 1'b0});
    db_q   <= per - PER_W'({lb, 1'b0});
    dc_q   <= per - PER_W'({lc, 1'b0});
    m1_q   <= (2*PER_W)'(per_q) * (2*PER_W)'(da_q);
    m2_q   <= (2*PER_W)'(db_q) * (2*PER_W)'(dc_q);
    ll_q   <= (2*HALF_W)'(m1_q[HALF_W-1:0]) * (2*HALF_W)'(m2_q[HALF_W-1:0]);
    lh_q   <= (2*HALF_W)'(m1_q[HALF_W-1:0]) * (2*HALF_W)'(m2_q[2*HALF_W-1:HALF_W]);
    hl_q   <= (2*HALF_W)'(m1_q[2*HALF_W-1:HALF_W]) * (2*HALF_W)'(m2_q[HALF_W-1:0]);
    hh_q   <= (2*HALF_W)'(m1_q[2*HALF_W-1:HALF_W]) * (2*HALF_W)'(m2_q[2*HALF_W-1:HALF_W]);
    prod_q <= (PROD_W'(hh_q) << (2 * HALF_W)) +
              ((PROD_W'(lh_q) + PROD_W'(hl_q)) << HALF_W) + PROD_W'(ll_q);
  end

  // Validity and perimeter travel alongside the product and area chain.
  always_ff @(posedge clk_i) begin
    ok_q[0] <= ok;
    pp_q[0] <= per;
    for (int k = 1; k < AROOT_W + 4; k++) begin
      ok_q[k] <= ok_q[k-1];
      pp_q[k] <= pp_q[k-1];
    end
  end

  // Area square root chain.
  assign ac[0].rad  = prod_q;
  assign ac[0].rem  = '0;
  assign ac[0].root = '0;
  for (genvar k = 0; k < AROOT_W; k++) begin : g_area
    tcpa_area_cell u_cell (
      .clk_i  (clk_i),
      .cell_i (ac[k]),
      .cell_o (ac[k+1])
    );
  end

  // Result register; an invalid triangle reads as zeros.
  assign area_full = ac[AROOT_W].root >> AREA_SH;

  always_ff @(posedge clk_i) begin
    res_q.is_triangle  <= ok_q[AROOT_W+3];
    res_q.perimeter_fx <= ok_q[AROOT_W+3] ? pp_q[AROOT_W+3] : '0;
    res_q.area_fx      <= ok_q[AROOT_W+3] ? area_full[AREA_W-1:0] : '0;
  end

  assign done_o = vld_q[LAT-1];
  assign res_o  = res_q;

endmodule

[hdl/tcpa_checker.sv]
module tcpa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input tcpa_pkg::tcpa_out_t res_o
);
  import tcpa_pkg::*;

  // The pipeline never refuses a word.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // Every accepted word yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("result missing after latency");

  // A rejected triangle carries zero perimeter and area.
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.is_triangle) |-> (res_o.perimeter_fx == '0 && res_o.area_fx == '0))
    else $error("nonzero result for invalid triangle");

  // A valid triangle has a positive perimeter.
  a_perim_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.is_triangle) |-> (res_o.perimeter_fx != '0))
    else $error("zero perimeter for valid triangle");

endmodule

bind triangle_check_perimeter_area_core tcpa_checker u_tcpa_checker (.*);
